/* rtl/ash_pkg.sv */
// Shared constants, field widths, command codes and the classified command type
// for the alignment statistics block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ash_pkg;

  // Field widths of the channels
  localparam int OP_W         = 2;
  localparam int GROUP_FIELD_W = 3;
  localparam int MAPQ_W       = 8;
  localparam int INSERT_W     = 32;
  localparam int ENTRY_W      = 14;
  localparam int VALUE_W      = 32;

  // Configuration registers
  localparam int LIMIT_W      = 15;
  localparam int FLOOR_W      = 8;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 15;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd10000;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 8'd0;

  localparam logic [CFG_INDEX_W-1:0] CFG_INSERT_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUALITY_FLOOR = 2'd1;

  // Defaults for the top-level parameters
  localparam int GROUPS_DEF     = 8;
  localparam int BINS_DEF       = 16384;
  localparam int COUNT_BITS_DEF = 32;

  // Event counters, one row of them per group
  localparam int NUM_COUNTERS = 9;
  localparam int CNT_SEL_W    = 4;
  localparam int CNT_TOTAL          = 0;
  localparam int CNT_UNMAPPED       = 1;
  localparam int CNT_UNPAIRED       = 2;
  localparam int CNT_UNPAIRED_DEDUP = 3;
  localparam int CNT_UNPAIRED_UNIQ  = 4;
  localparam int CNT_PAIRED         = 5;
  localparam int CNT_PAIRED_DEDUP   = 6;
  localparam int CNT_PAIRED_UNIQ    = 7;
  localparam int CNT_PAIRED_PROPER  = 8;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD   = 2'd0,
    OP_READ_CNT = 2'd1,
    OP_READ_BIN = 2'd2
  } ash_op_t;

  typedef enum logic [1:0] {
    KIND_RECORD   = 2'd0,
    KIND_READ_CNT = 2'd1,
    KIND_READ_BIN = 2'd2
  } ash_kind_t;

  // Classified command handed from the front end to the update engine
  typedef struct packed {
    ash_kind_t                 kind;
    logic [NUM_COUNTERS-1:0]   inc;
    logic                      hist_inc;
    logic [CNT_SEL_W-1:0]      cnt_sel;
    logic                      err;
  } ash_cmd_t;

endpackage

`default_nettype wire

/* rtl/ash_if.sv */
// Channel interfaces of the alignment statistics block: input words, result
// words and configuration writes. Depends on ash_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ash_in_if
  import ash_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             op;
  logic [GROUP_FIELD_W-1:0]    group;
  logic                        first_mate;
  logic                        mapped;
  logic                        mate_mapped;
  logic                        duplicate;
  logic                        proper_pair;
  logic [MAPQ_W-1:0]           map_quality;
  logic signed [INSERT_W-1:0]  insert_size;
  logic [ENTRY_W-1:0]          entry_index;

  modport source (
    output valid, op, group, first_mate, mapped, mate_mapped, duplicate,
           proper_pair, map_quality, insert_size, entry_index,
    input  ready
  );
  modport sink (
    input  valid, op, group, first_mate, mapped, mate_mapped, duplicate,
           proper_pair, map_quality, insert_size, entry_index,
    output ready
  );
endinterface

interface ash_out_if
  import ash_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_value;
  logic               index_error;

  modport source (output valid, read_value, index_error, input ready);
  modport sink   (input valid, read_value, index_error, output ready);
endinterface

interface ash_cfg_if
  import ash_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/ash_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ash_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/ash_front.sv */
// Front end: takes input words and configuration writes, holds the two
// configuration registers and classifies each word into a command. Uses ash_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ash_front
  import ash_pkg::*;
#(
  parameter int GROUPS = GROUPS_DEF,
  parameter int BINS   = BINS_DEF,
  localparam int ROW_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1,
  localparam int HADDR_W = $clog2(GROUPS * BINS)
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ash_in_if.sink           in_ch,
  ash_cfg_if.sink          cfg_ch,
  input  wire logic        q_full,
  input  wire logic        clearing,
  output logic             push,
  output ash_cmd_t         push_cmd,
  output logic [ROW_W-1:0]   push_row,
  output logic [HADDR_W-1:0] push_haddr
);

  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [FLOOR_W-1:0] floor_r, floor_nxt;

  logic              group_ok;
  logic              uniq;
  logic              enq;
  logic [INSERT_W-1:0] raw;
  logic [INSERT_W-1:0] mag;
  logic [ROW_W-1:0]  row;
  logic [HADDR_W-1:0] bin_base;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    limit_nxt = limit_r;
    floor_nxt = floor_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_INSERT_LIMIT:  limit_nxt = cfg_ch.data[LIMIT_W-1:0];
        CFG_QUALITY_FLOOR: floor_nxt = cfg_ch.data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      floor_r <= FLOOR_RESET;
    end else begin
      limit_r <= limit_nxt;
      floor_r <= floor_nxt;
    end
  end

  assign in_ch.ready = ~q_full & ~clearing;

  always_comb begin
    raw      = in_ch.insert_size;
    mag      = raw[INSERT_W-1] ? (~raw + 32'd1) : raw;
    group_ok = 32'(in_ch.group) < GROUPS;
    uniq     = in_ch.map_quality > floor_r;
    row      = ROW_W'(in_ch.group);
    bin_base = HADDR_W'(row) * HADDR_W'(BINS);

    enq        = 1'b0;
    push_cmd   = '0;
    push_row   = row;
    push_haddr = '0;

    unique case (ash_op_t'(in_ch.op))
      OP_RECORD: begin
        enq           = group_ok;
        push_cmd.kind = KIND_RECORD;
        push_cmd.inc[CNT_TOTAL] = in_ch.first_mate;
        if (!in_ch.mapped && !in_ch.mate_mapped) begin
          push_cmd.inc[CNT_UNMAPPED] = in_ch.first_mate;
        end else if (in_ch.mapped && in_ch.mate_mapped) begin
          push_cmd.inc[CNT_PAIRED] = in_ch.first_mate;
          if (in_ch.first_mate && !in_ch.duplicate) begin
            push_cmd.inc[CNT_PAIRED_DEDUP]  = 1'b1;
            push_cmd.inc[CNT_PAIRED_UNIQ]   = uniq;
            push_cmd.inc[CNT_PAIRED_PROPER] = in_ch.proper_pair;
            push_cmd.hist_inc = (mag != '0) && (mag < 32'(limit_r)) && (mag < 32'(BINS));
          end
        end else begin
          push_cmd.inc[CNT_UNPAIRED] = in_ch.first_mate;
          if (in_ch.mapped && !in_ch.duplicate) begin
            push_cmd.inc[CNT_UNPAIRED_DEDUP] = 1'b1;
            push_cmd.inc[CNT_UNPAIRED_UNIQ]  = uniq;
          end
        end
        push_haddr = bin_base + HADDR_W'(mag);
      end
      OP_READ_CNT: begin
        enq              = 1'b1;
        push_cmd.kind    = KIND_READ_CNT;
        push_cmd.cnt_sel = in_ch.entry_index[CNT_SEL_W-1:0];
        push_cmd.err     = !group_ok || (in_ch.entry_index >= ENTRY_W'(NUM_COUNTERS));
        if (push_cmd.err) begin
          push_row = '0;
        end
      end
      OP_READ_BIN: begin
        enq           = 1'b1;
        push_cmd.kind = KIND_READ_BIN;
        push_cmd.err  = !group_ok || (32'(in_ch.entry_index) >= BINS);
        if (push_cmd.err) begin
          push_row = '0;
        end else begin
          push_haddr = bin_base + HADDR_W'(in_ch.entry_index);
        end
      end
      default: ;
    endcase
  end

  assign push = in_ch.valid & in_ch.ready & enq;

endmodule

`default_nettype wire

/* rtl/ash_queue.sv */
// Short FIFO between the front end and the update engine; carries packed
// commands of any width. Uses ash_pkg for the depth.
`timescale 1ns / 1ps
`default_nettype none

module ash_queue
  import ash_pkg::*;
#(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic      [W-1:0] pop_data,
  output logic              not_empty,
  output logic              full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign not_empty = fill_r != '0;
  assign full      = fill_r == CNT_W'(QUEUE_DEPTH);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/ash_back.sv */
// Update engine: clears both stores after reset, then runs each record as a
// read-modify-write on the counter RAM and histogram RAM and drives a result for each read.
// Uses ash_pkg and ash_ram.
`timescale 1ns / 1ps
`default_nettype none

module ash_back
  import ash_pkg::*;
#(
  parameter int GROUPS     = GROUPS_DEF,
  parameter int BINS       = BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int ROW_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1,
  localparam int HDEPTH  = GROUPS * BINS,
  localparam int HADDR_W = $clog2(HDEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire ash_cmd_t           q_cmd,
  input  wire logic [ROW_W-1:0]   q_row,
  input  wire logic [HADDR_W-1:0] q_haddr,
  output logic                    q_pop,
  output logic                    clearing,
  ash_out_if.source               out_ch
);

  localparam int ROW_BITS = NUM_COUNTERS * COUNT_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_APPLY = 3'b100
  } ash_state_t;

  ash_state_t          state_r, state_nxt;
  logic [HADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  ash_cmd_t            cmd_r;
  logic [ROW_W-1:0]    row_r;
  logic [HADDR_W-1:0]  haddr_r;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_err_r, out_err_nxt;

  logic                  row_we;
  logic [ROW_W-1:0]      row_waddr;
  logic [ROW_BITS-1:0]   row_wdata;
  logic [ROW_BITS-1:0]   row_rdata;
  logic                  hist_we;
  logic [HADDR_W-1:0]    hist_waddr;
  logic [COUNT_BITS-1:0] hist_wdata;
  logic [COUNT_BITS-1:0] hist_rdata;

  logic [ROW_BITS-1:0]   row_bumped;
  logic [COUNT_BITS-1:0] hist_bumped;
  logic [COUNT_BITS-1:0] cnt_sel_val;
  logic [VALUE_W-1:0]    cnt_val32;
  logic [VALUE_W-1:0]    hist_val32;
  logic                  out_free;

  ash_ram #(.WIDTH(ROW_BITS), .DEPTH(GROUPS)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (row_wdata),
    .rd_en   (q_pop),
    .rd_addr (q_row),
    .rd_data (row_rdata)
  );

  ash_ram #(.WIDTH(COUNT_BITS), .DEPTH(HDEPTH)) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (hist_wdata),
    .rd_en   (q_pop),
    .rd_addr (q_haddr),
    .rd_data (hist_rdata)
  );

  // Saturating increments of the fetched row and bin
  always_comb begin
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      if (cmd_r.inc[k] && !(&row_rdata[k*COUNT_BITS +: COUNT_BITS])) begin
        row_bumped[k*COUNT_BITS +: COUNT_BITS] = row_rdata[k*COUNT_BITS +: COUNT_BITS] + 1'b1;
      end else begin
        row_bumped[k*COUNT_BITS +: COUNT_BITS] = row_rdata[k*COUNT_BITS +: COUNT_BITS];
      end
    end
    hist_bumped = (&hist_rdata) ? hist_rdata : hist_rdata + 1'b1;
    cnt_sel_val = row_rdata[cmd_r.cnt_sel*COUNT_BITS +: COUNT_BITS];
  end

  // Clamp to the result width
  generate
    if (COUNT_BITS > VALUE_W) begin : g_clamp
      assign cnt_val32  = (|cnt_sel_val[COUNT_BITS-1:VALUE_W]) ? '1 : cnt_sel_val[VALUE_W-1:0];
      assign hist_val32 = (|hist_rdata[COUNT_BITS-1:VALUE_W]) ? '1 : hist_rdata[VALUE_W-1:0];
    end else begin : g_extend
      assign cnt_val32  = VALUE_W'(cnt_sel_val);
      assign hist_val32 = VALUE_W'(hist_rdata);
    end
  endgenerate

  assign out_free = ~out_valid_r | out_ch.ready;
  assign clearing = state_r == ST_CLEAR;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    q_pop         = 1'b0;
    row_we        = 1'b0;
    row_waddr     = row_r;
    row_wdata     = row_bumped;
    hist_we       = 1'b0;
    hist_waddr    = haddr_r;
    hist_wdata    = hist_bumped;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;

    unique case (state_r)
      ST_CLEAR: begin
        row_we      = 32'(clr_cnt_r) < GROUPS;
        row_waddr   = ROW_W'(clr_cnt_r);
        row_wdata   = '0;
        hist_we     = 1'b1;
        hist_waddr  = clr_cnt_r;
        hist_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == HADDR_W'(HDEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        unique case (cmd_r.kind)
          KIND_RECORD: begin
            row_we    = 1'b1;
            hist_we   = cmd_r.hist_inc;
            state_nxt = ST_IDLE;
          end
          KIND_READ_CNT, KIND_READ_BIN: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_err_nxt   = cmd_r.err;
              if (cmd_r.err) begin
                out_value_nxt = '0;
              end else if (cmd_r.kind == KIND_READ_CNT) begin
                out_value_nxt = cnt_val32;
              end else begin
                out_value_nxt = hist_val32;
              end
              state_nxt = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
    if (q_pop) begin
      cmd_r   <= q_cmd;
      row_r   <= q_row;
      haddr_r <= q_haddr;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_value_r;
  assign out_ch.index_error = out_err_r;

endmodule

`default_nettype wire

/* rtl/alignment_stats_histogram.sv */
// Top level of the alignment statistics block: front end, command queue and
// update engine. Uses ash_pkg, ash_if, ash_front, ash_queue and ash_back.
//
//   port    role    words carried
//   ------  ------  ---------------------------------------------------------
//   in_ch   sink    record / read-counter / read-bin commands with flags
//   out_ch  source  one read_value + index_error word per read command
//   cfg_ch  sink    register writes: 0 insert_limit, 1 quality_floor
//
// The front end takes one word per cycle while the two-entry queue has room.
// The update engine runs each command in ST_IDLE (pop and RAM read), then
// ST_APPLY (modify and write back), and takes no new command before the
// last is through; a read command waits in ST_APPLY while a result stalls.
// Records for a group out of range and the unused op are dropped in the front.
// After reset both stores are swept to zero, one entry per cycle, over
// GROUPS*BINS entries (131072 at defaults); in_ch.ready stays low meanwhile.
// cfg_ch.ready is always high. A stalled result holds in the output register
// while the front keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module alignment_stats_histogram
  import ash_pkg::*;
#(
  parameter int GROUPS     = GROUPS_DEF,
  parameter int BINS       = BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ash_in_if.sink     in_ch,
  ash_out_if.source  out_ch,
  ash_cfg_if.sink    cfg_ch
);

  localparam int ROW_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int HADDR_W = $clog2(GROUPS * BINS);
  localparam int CMD_W   = $bits(ash_cmd_t);
  localparam int Q_W     = CMD_W + ROW_W + HADDR_W;

  // Front end to queue
  logic               push;
  ash_cmd_t           push_cmd;
  logic [ROW_W-1:0]   push_row;
  logic [HADDR_W-1:0] push_haddr;

  // Queue to update engine
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic [Q_W-1:0]     q_rdata;
  ash_cmd_t           q_cmd;
  logic [ROW_W-1:0]   q_row;
  logic [HADDR_W-1:0] q_haddr;

  // Hold input words off while the stores are being swept
  logic               clearing;

  ash_front #(.GROUPS(GROUPS), .BINS(BINS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_row   (push_row),
    .push_haddr (push_haddr)
  );

  ash_queue #(.W(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_cmd, push_row, push_haddr}),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_valid),
    .full      (q_full)
  );

  assign {q_cmd, q_row, q_haddr} = q_rdata;

  ash_back #(.GROUPS(GROUPS), .BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_row    (q_row),
    .q_haddr  (q_haddr),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/ash_checker.sv */
// Port-level checks on the alignment statistics block, attached to the top
// level by the bind below. Uses ash_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ash_checker
  import ash_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [VALUE_W-1:0] out_value,
  input wire logic               out_err
);

  // A result waiting on the sink stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // An index error always reads as zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err |-> out_value == '0)
    else $error("index error with nonzero value");

  // Reset leaves no result pending
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The clearing sweep starts right after reset and blocks input words
  a_rst_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input accepted before the stores were cleared");

endmodule

bind alignment_stats_histogram ash_checker u_ash_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.read_value),
  .out_err   (out_ch.index_error)
);

`default_nettype wire
